// ===== rtl/lri_pkg.sv =====
// Shared types and constants for the logistic regression inference block.
// Holds the input and result request structs, register codes and sigmoid constants.
// Depends on nothing; used by logistic_regression_inference.
`default_nettype none

package lri_pkg;

  // Default weight store depth
  localparam int unsigned MAX_FEATURES_DEF = 256;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS          = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 1'b1;

  // Input opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Position counter saturates at all ones
  localparam logic [8:0] POS_LIMIT = 9'd511;

  // Result queue depth (covers the pipeline plus a few waiting results)
  localparam int unsigned RES_DEPTH = 8;

  // PLAN sigmoid breakpoints in Q8.24 and offsets in Q1.15
  localparam logic [31:0] Z_FIVE    = 32'd83886080;
  localparam logic [31:0] Z_TWO375  = 32'd39845888;
  localparam logic [31:0] Z_ONE     = 32'd16777216;
  localparam logic [15:0] Q15_ONE   = 16'd32768;
  localparam logic [15:0] OFS_HIGH  = 16'd27648;
  localparam logic [15:0] OFS_MID   = 16'd20480;
  localparam logic [15:0] OFS_LOW   = 16'd16384;

  typedef struct packed {
    logic               opcode;
    logic [7:0]         index;
    logic signed [15:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        probability;
    logic               predicted_class;
    logic signed [31:0] score;
    logic               size_error;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/logistic_regression_inference.sv =====
// Logistic regression inference: one feature or weight load per cycle while in_ready is high,
// results pass s1 to s4, then a small result queue toward out_*. Depends on lri_pkg, lri_ram.
// Throughput: one input request per cycle while in_ready is high, set by the single weight-store
// read port and one MAC. A result is offered once its last feature has passed s1 to s4;
// up to 8 results may be outstanding before in_ready drops. Reset: synchronous, clears control,
// bias (0) and feature_count (1); the weight store is not cleared and needs loading before use.
`default_nettype none

module logistic_regression_inference #(
  parameter int unsigned MAX_FEATURES = lri_pkg::MAX_FEATURES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire lri_pkg::in_item_t                in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output lri_pkg::out_item_t                    out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [lri_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lri_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned AW  = $clog2(MAX_FEATURES);
  localparam int unsigned QPW = $clog2(lri_pkg::RES_DEPTH);
  localparam int unsigned QCW = $clog2(lri_pkg::RES_DEPTH + 1);

  // Configuration registers
  logic [31:0] bias_r;
  logic [8:0]  fc_r;

  // Accept-stage state
  logic [8:0] pos_r, pos_nxt;
  logic       ovf_r, ovf_nxt;
  logic       in_acc, feat_acc, load_acc;
  logic       feat_en, feat_err;
  logic [8:0] pos_inc;
  logic       ovf_inc;

  // Pipeline registers
  logic               s1_valid_r, s1_en_r, s1_last_r, s1_err_r;
  logic signed [15:0] s1_value_r;
  logic [15:0]        ram_rdata;
  logic signed [31:0] mul;
  logic               s2_valid_r, s2_last_r, s2_err_r;
  logic [31:0]        s2_prod_r;
  logic [47:0]        acc_r, acc_sum;
  logic               s3_valid_r, s3_err_r;
  logic [47:0]        s3_total_r;
  logic [48:0]        z_wide;
  logic [31:0]        z_sat;
  logic               s4_valid_r, s4_err_r;
  logic [31:0]        s4_score_r;

  // Sigmoid and result
  logic [31:0]         mag;
  logic [15:0]         y;
  lri_pkg::out_item_t  res;

  // Result queue
  lri_pkg::out_item_t q_mem [lri_pkg::RES_DEPTH];
  logic [QPW-1:0]     q_wr_r, q_rd_r;
  logic [QCW-1:0]     q_cnt_r, q_cnt_nxt;
  logic [QCW-1:0]     res_cnt_r, res_cnt_nxt;
  logic               q_pop, res_take;

  assign cfg_ready = 1'b1;
  assign in_ready  = (res_cnt_r < QCW'(lri_pkg::RES_DEPTH));
  assign in_acc    = in_valid && in_ready;
  assign feat_acc  = in_acc && (in_data.opcode == lri_pkg::OP_SAMPLE);
  assign load_acc  = in_acc && (in_data.opcode == lri_pkg::OP_LOAD) &&
                     (32'(in_data.index) < 32'(MAX_FEATURES));

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
      fc_r   <= 9'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lri_pkg::REG_BIAS:          bias_r <= cfg_data;
        lri_pkg::REG_FEATURE_COUNT: fc_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Weight store: loads write, the current position is read every cycle
  lri_ram #(
    .WIDTH(16),
    .DEPTH(MAX_FEATURES)
  ) u_weights (
    .clk   (clk),
    .we    (load_acc),
    .waddr (AW'(in_data.index)),
    .wdata (in_data.value),
    .raddr (AW'(pos_r)),
    .rdata (ram_rdata)
  );

  // Advance position; decide accumulate enable and size error at accept
  always_comb begin
    feat_en = (pos_r < fc_r) && (32'(pos_r) < 32'(MAX_FEATURES));
    if (pos_r >= lri_pkg::POS_LIMIT) begin
      pos_inc = pos_r;
      ovf_inc = 1'b1;
    end else begin
      pos_inc = pos_r + 9'd1;
      ovf_inc = ovf_r;
    end
    feat_err = ovf_inc || (fc_r == 9'd0) || (32'(fc_r) > 32'(MAX_FEATURES)) ||
               (pos_inc != fc_r);
    pos_nxt = pos_r;
    ovf_nxt = ovf_r;
    if (feat_acc) begin
      if (in_data.last) begin
        pos_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        pos_nxt = pos_inc;
        ovf_nxt = ovf_inc;
      end
    end
  end

  // Multiply and accumulate
  assign mul     = s1_en_r ? (s1_value_r * $signed(ram_rdata)) : 32'sd0;
  assign acc_sum = acc_r + {{16{s2_prod_r[31]}}, s2_prod_r};

  // Add bias and saturate to 32 bits
  always_comb begin
    z_wide = {s3_total_r[47], s3_total_r} + {{17{bias_r[31]}}, bias_r};
    if (!z_wide[48] && (|z_wide[47:31])) begin
      z_sat = 32'h7FFF_FFFF;
    end else if (z_wide[48] && !(&z_wide[47:31])) begin
      z_sat = 32'h8000_0000;
    end else begin
      z_sat = z_wide[31:0];
    end
  end

  // PLAN sigmoid on the saturated score
  always_comb begin
    mag = s4_score_r[31] ? (32'd0 - s4_score_r) : s4_score_r;
    if (mag >= lri_pkg::Z_FIVE) begin
      y = lri_pkg::Q15_ONE;
    end else if (mag >= lri_pkg::Z_TWO375) begin
      y = 16'(mag >> 14) + lri_pkg::OFS_HIGH;
    end else if (mag >= lri_pkg::Z_ONE) begin
      y = 16'(mag >> 12) + lri_pkg::OFS_MID;
    end else begin
      y = 16'(mag >> 11) + lri_pkg::OFS_LOW;
    end
    if (s4_err_r) begin
      res.probability     = '0;
      res.predicted_class = 1'b0;
      res.score           = '0;
      res.size_error      = 1'b1;
    end else begin
      res.probability     = s4_score_r[31] ? (lri_pkg::Q15_ONE - y) : y;
      res.predicted_class = !s4_score_r[31];
      res.score           = s4_score_r;
      res.size_error      = 1'b0;
    end
  end

  // Hold the count of results reserved and queued
  assign q_pop    = out_valid && out_ready;
  assign res_take = feat_acc && in_data.last;
  always_comb begin
    res_cnt_nxt = res_cnt_r;
    if (res_take && !q_pop) begin
      res_cnt_nxt = res_cnt_r + QCW'(1);
    end else if (!res_take && q_pop) begin
      res_cnt_nxt = res_cnt_r - QCW'(1);
    end
    q_cnt_nxt = q_cnt_r;
    if (s4_valid_r && !q_pop) begin
      q_cnt_nxt = q_cnt_r + QCW'(1);
    end else if (!s4_valid_r && q_pop) begin
      q_cnt_nxt = q_cnt_r - QCW'(1);
    end
  end

  // Control registers of the pipeline and queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      ovf_r      <= 1'b0;
      acc_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      q_wr_r     <= '0;
      q_rd_r     <= '0;
      q_cnt_r    <= '0;
      res_cnt_r  <= '0;
    end else begin
      pos_r      <= pos_nxt;
      ovf_r      <= ovf_nxt;
      s1_valid_r <= feat_acc;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r && s2_last_r;
      s4_valid_r <= s3_valid_r;
      if (s2_valid_r) begin
        acc_r <= s2_last_r ? 48'd0 : acc_sum;
      end
      if (s4_valid_r) begin
        q_wr_r <= (q_wr_r == QPW'(lri_pkg::RES_DEPTH - 1)) ? '0 : q_wr_r + QPW'(1);
      end
      if (q_pop) begin
        q_rd_r <= (q_rd_r == QPW'(lri_pkg::RES_DEPTH - 1)) ? '0 : q_rd_r + QPW'(1);
      end
      q_cnt_r   <= q_cnt_nxt;
      res_cnt_r <= res_cnt_nxt;
    end
  end

  // Payload registers of the pipeline and queue
  always_ff @(posedge clk) begin
    s1_value_r <= in_data.value;
    s1_en_r    <= feat_en;
    s1_last_r  <= in_data.last;
    s1_err_r   <= feat_err;
    s2_prod_r  <= mul;
    s2_last_r  <= s1_last_r;
    s2_err_r   <= s1_err_r;
    s3_total_r <= acc_sum;
    s3_err_r   <= s2_err_r;
    s4_score_r <= z_sat;
    s4_err_r   <= s3_err_r;
    if (s4_valid_r) begin
      q_mem[q_wr_r] <= res;
    end
  end

  assign out_valid = (q_cnt_r != '0);
  assign out_data  = q_mem[q_rd_r];

  // Queue never holds more than was reserved at accept
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= res_cnt_r) else $error("result queue exceeds reservations");

  // Reservations never exceed the queue depth
  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= QCW'(lri_pkg::RES_DEPTH)) else $error("reservation count overflow");

  // A finished score only follows a vector end in the accumulate stage
  a_s3_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> $past(s2_valid_r && s2_last_r)) else $error("score stage without last");

  // A size error carries zeroed result fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.size_error) |->
      (out_data.probability == '0 && out_data.score == '0 && !out_data.predicted_class))
    else $error("size error with nonzero fields");

endmodule

`default_nettype wire

// ===== rtl/lri_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No reset on the array; used for the weight store. Depends on nothing.
`default_nettype none

module lri_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
